@@ sv/lcc_pkg.sv @@
`timescale 1ns / 1ps
package lcc_pkg;

  localparam int TimeW    = 32;
  localparam int ChanW    = 8;
  localparam int TailW    = 5;
  localparam int PixIdxW  = 4;
  localparam int ProdW    = 16;
  localparam int OutDataW = 32;
  localparam int ApbAddrW = 5;
  localparam int ApbDataW = 32;

  localparam logic [ChanW-1:0] FixedIntervalMs = 8'd40;
  localparam logic [ChanW-1:0] MapMinMs        = 8'd10;
  localparam logic [ChanW-1:0] MapSpanMs       = 8'd190;
  localparam logic [ChanW-1:0] FullLevel       = 8'd255;

  localparam logic [2:0] REG_BASE_RED      = 3'd0;
  localparam logic [2:0] REG_BASE_GREEN    = 3'd1;
  localparam logic [2:0] REG_BASE_BLUE     = 3'd2;
  localparam logic [2:0] REG_SPEED_SETTING = 3'd3;
  localparam logic [2:0] REG_INTERVAL_MODE = 3'd4;
  localparam logic [2:0] REG_TAIL_LENGTH   = 3'd5;

  typedef struct packed {
    logic [ChanW-1:0] base_red;
    logic [ChanW-1:0] base_green;
    logic [ChanW-1:0] base_blue;
    logic [ChanW-1:0] speed_setting;
    logic             interval_mode;
    logic [TailW-1:0] tail_length;
  } lcc_cfg_t;

  typedef struct packed {
    logic take_in;
    logic diff;
    logic start;
    logic mul;
    logic load_out;
    logic advance;
    logic head_adv;
  } lcc_cmd_t;

  typedef struct packed {
    logic fire;
    logic tail_zero;
    logic last;
    logic out_free;
  } lcc_sts_t;

  function automatic logic [ChanW-1:0] bri_of(input logic [TailW-1:0] k);
    logic [ChanW-1:0] b;
    case (k)
      5'd1:    b = 8'd255;
      5'd2:    b = 8'd127;
      5'd3:    b = 8'd85;
      5'd4:    b = 8'd63;
      5'd5:    b = 8'd51;
      5'd6:    b = 8'd42;
      5'd7:    b = 8'd36;
      5'd8:    b = 8'd31;
      5'd9:    b = 8'd28;
      5'd10:   b = 8'd25;
      5'd11:   b = 8'd23;
      5'd12:   b = 8'd21;
      5'd13:   b = 8'd19;
      5'd14:   b = 8'd18;
      5'd15:   b = 8'd17;
      5'd16:   b = 8'd15;
      5'd17:   b = 8'd15;
      5'd18:   b = 8'd14;
      5'd19:   b = 8'd13;
      5'd20:   b = 8'd12;
      5'd21:   b = 8'd12;
      5'd22:   b = 8'd11;
      5'd23:   b = 8'd11;
      5'd24:   b = 8'd10;
      5'd25:   b = 8'd10;
      5'd26:   b = 8'd9;
      5'd27:   b = 8'd9;
      5'd28:   b = 8'd9;
      5'd29:   b = 8'd8;
      5'd30:   b = 8'd8;
      5'd31:   b = 8'd8;
      default: b = 8'd0;
    endcase
    return b;
  endfunction

  // divide by 255: reciprocal estimate, then one correction either way
  function automatic logic [ChanW-1:0] div255(input logic [ProdW-1:0] p);
    logic [8:0]  q;
    logic [16:0] qx;
    logic [16:0] pe;
    pe = {1'b0, p};
    q  = 9'((pe + 17'(p[15:8]) + 17'd1) >> 8);
    qx = {q, 8'b0} - 17'(q);
    if (qx > pe) begin
      q = q - 9'd1;
    end else if ((pe - qx) >= 17'(FullLevel)) begin
      q = q + 9'd1;
    end
    return q[ChanW-1:0];
  endfunction

endpackage

@@ sv/lcc_regs.sv @@
`timescale 1ns / 1ps
module lcc_regs
  import lcc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  output lcc_cfg_t            cfg_o
);

  lcc_cfg_t   cfg_q;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:2];
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_red      <= 8'd255;
      cfg_q.base_green    <= 8'd0;
      cfg_q.base_blue     <= 8'd0;
      cfg_q.speed_setting <= 8'd128;
      cfg_q.interval_mode <= 1'b0;
      cfg_q.tail_length   <= 5'd5;
    end else if (wr_en) begin
      case (reg_idx)
        REG_BASE_RED:      cfg_q.base_red      <= pwdata[ChanW-1:0];
        REG_BASE_GREEN:    cfg_q.base_green    <= pwdata[ChanW-1:0];
        REG_BASE_BLUE:     cfg_q.base_blue     <= pwdata[ChanW-1:0];
        REG_SPEED_SETTING: cfg_q.speed_setting <= pwdata[ChanW-1:0];
        REG_INTERVAL_MODE: cfg_q.interval_mode <= pwdata[0];
        REG_TAIL_LENGTH:   cfg_q.tail_length   <= pwdata[TailW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BASE_RED:      prdata = ApbDataW'(cfg_q.base_red);
      REG_BASE_GREEN:    prdata = ApbDataW'(cfg_q.base_green);
      REG_BASE_BLUE:     prdata = ApbDataW'(cfg_q.base_blue);
      REG_SPEED_SETTING: prdata = ApbDataW'(cfg_q.speed_setting);
      REG_INTERVAL_MODE: prdata = ApbDataW'(cfg_q.interval_mode);
      REG_TAIL_LENGTH:   prdata = ApbDataW'(cfg_q.tail_length);
      default:           prdata = '0;
    endcase
  end

endmodule

@@ sv/lcc_ctrl.sv @@
`timescale 1ns / 1ps
module lcc_ctrl
  import lcc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  lcc_sts_t sts_i,
  output lcc_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIFF  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_LOAD  = 3'd4;

  logic [2:0] state_q;
  logic [2:0] state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take_in = 1'b1;
          state_d       = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd_o.diff = 1'b1;
        state_d    = S_CHECK;
      end
      S_CHECK: begin
        if (sts_i.fire) begin
          cmd_o.start = 1'b1;
          if (sts_i.tail_zero) begin
            cmd_o.head_adv = 1'b1;
            state_d        = S_IDLE;
          end else begin
            state_d = S_MUL;
          end
        end else begin
          state_d = S_IDLE;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_LOAD;
      end
      S_LOAD: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          if (sts_i.last) begin
            cmd_o.head_adv = 1'b1;
            state_d        = S_IDLE;
          end else begin
            cmd_o.advance = 1'b1;
            state_d       = S_MUL;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ sv/lcc_dp.sv @@
`timescale 1ns / 1ps
module lcc_dp
  import lcc_pkg::*;
#(
  parameter int RING_PIXELS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lcc_cfg_t            cfg_i,
  input  lcc_cmd_t            cmd_i,
  output lcc_sts_t            sts_o,
  input  logic [TimeW-1:0]    now_ms_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [OutDataW-1:0] out_data_o,
  output logic                out_last_o
);

  localparam int PosW = $clog2(RING_PIXELS);
  localparam logic [PosW-1:0] PosMax = PosW'(RING_PIXELS - 1);

  logic [TimeW-1:0]   now_q;
  logic [TimeW-1:0]   diff_q;
  logic [TimeW-1:0]   last_step_q;
  logic [ChanW-1:0]   interval_q;
  logic [ChanW-1:0]   interval_d;
  logic [ChanW-1:0]   speed_gap;
  logic [ProdW-1:0]   map_prod;
  logic [PosW-1:0]    head_q;
  logic [PosW-1:0]    pos_q;
  logic [TailW-1:0]   k_q;
  logic [ChanW-1:0]   bri;
  logic [ProdW-1:0]   prod_r_q;
  logic [ProdW-1:0]   prod_g_q;
  logic [ProdW-1:0]   prod_b_q;
  logic               out_valid_q;
  logic               out_last_q;
  logic [PixIdxW-1:0] pix_q;
  logic [ChanW-1:0]   red_q;
  logic [ChanW-1:0]   green_q;
  logic [ChanW-1:0]   blue_q;

  assign speed_gap  = FullLevel - cfg_i.speed_setting;
  assign map_prod   = ProdW'(speed_gap) * ProdW'(MapSpanMs);
  assign interval_d = cfg_i.interval_mode ? (div255(map_prod) + MapMinMs) : FixedIntervalMs;
  assign bri        = bri_of(k_q);

  assign sts_o.fire      = (diff_q >= TimeW'(interval_q));
  assign sts_o.tail_zero = (cfg_i.tail_length == '0);
  assign sts_o.last      = (k_q == TailW'(1));
  assign sts_o.out_free  = ~out_valid_q | out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_last_o  = out_last_q;
  assign out_data_o  = OutDataW'({blue_q, green_q, red_q, pix_q});

  always_ff @(posedge clk_i) begin
    interval_q <= interval_d;
    if (cmd_i.take_in) begin
      now_q <= now_ms_i;
    end
    if (cmd_i.diff) begin
      diff_q <= now_q - last_step_q;
    end
    if (cmd_i.mul) begin
      prod_r_q <= ProdW'(cfg_i.base_red) * ProdW'(bri);
      prod_g_q <= ProdW'(cfg_i.base_green) * ProdW'(bri);
      prod_b_q <= ProdW'(cfg_i.base_blue) * ProdW'(bri);
    end
    if (cmd_i.load_out) begin
      pix_q      <= PixIdxW'(pos_q);
      red_q      <= div255(prod_r_q);
      green_q    <= div255(prod_g_q);
      blue_q     <= div255(prod_b_q);
      out_last_q <= (k_q == TailW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_step_q <= '0;
      head_q      <= '0;
      pos_q       <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        last_step_q <= now_q;
        pos_q       <= head_q;
        k_q         <= cfg_i.tail_length;
      end else if (cmd_i.advance) begin
        pos_q <= (pos_q == PosMax) ? '0 : pos_q + 1'b1;
        k_q   <= k_q - 1'b1;
      end
      if (cmd_i.head_adv) begin
        head_q <= (head_q == PosMax) ? '0 : head_q + 1'b1;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten while holding a transfer");

  a_mul_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mul |-> (k_q != '0))
    else $error("pixel computed with no tail left");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q <= PosMax) && (head_q <= PosMax))
    else $error("ring position out of range");

  a_head_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.head_adv |=> (head_q != $past(head_q)))
    else $error("head did not advance after a step");
`endif

endmodule

@@ sv/led_comet_chase_generator.sv @@
`timescale 1ns / 1ps
// channel   direction  transfer contents
// s_axis    in         tdata[31:0] now_ms
// m_axis    out        tdata pixel_index, red_out, green_out, blue_out; tlast frame_last
// apb       in/out     six registers at byte address 4*i
//
// Each item passes the take-in, difference and check states; a firing one then computes
// each tail pixel in turn, with the multiply and divide-by-255 pair reused for every pixel.
// rst_ni clears registers to their defaults, the step time and the head to zero.
// A stalled m_axis holds the current pixel; the next pixel waits for it.
// s_axis is ready again once the last pixel sits in the output register.
module led_comet_chase_generator
  import lcc_pkg::*;
#(
  parameter int RING_PIXELS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [TimeW-1:0]    s_axis_tdata,   // [31:0] now_ms
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [3:0] pixel_index, [11:4] red_out, [19:12] green_out, [27:20] blue_out
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic                m_axis_tlast,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  lcc_cfg_t cfg;
  lcc_cmd_t cmd;
  lcc_sts_t sts;

  lcc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lcc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lcc_dp #(
    .RING_PIXELS (RING_PIXELS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .now_ms_i    (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

@@ dv/lcc_frame_checker.sv @@
`timescale 1ns / 1ps
module lcc_frame_checker
  import lcc_pkg::*;
#(
  parameter int RingPixels = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [TimeW-1:0]    s_axis_tdata,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [OutDataW-1:0] m_axis_tdata,
  input  logic                m_axis_tlast,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  input  logic [ApbDataW-1:0] prdata,
  input  logic                pready,
  output int                  writes_pending_o,
  output int                  mismatches_o
);

  typedef struct packed {
    logic [PixIdxW-1:0] idx;
    logic [ChanW-1:0]   red;
    logic [ChanW-1:0]   green;
    logic [ChanW-1:0]   blue;
    logic               last;
  } pixel_wr_t;

  lcc_cfg_t         regs;
  logic [TimeW-1:0] last_step_ms;
  int unsigned      head_pos;
  pixel_wr_t        pixel_writes_q[$];
  int               mismatches;

  function automatic int unsigned step_interval_ms();
    if (!regs.interval_mode) begin
      return int'(FixedIntervalMs);
    end
    return (int'(FullLevel) - int'(regs.speed_setting)) * int'(MapSpanMs) / int'(FullLevel)
           + int'(MapMinMs);
  endfunction

  function automatic logic [ChanW-1:0] scale_chan(input logic [ChanW-1:0] base,
                                                  input int unsigned bri);
    return ChanW'(int'(base) * bri / int'(FullLevel));
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s", $time, msg);
    end
  endtask

  task automatic predict_frame(input logic [TimeW-1:0] now_ms);
    logic [TimeW-1:0] since;
    int unsigned      bri;
    pixel_wr_t        w;
    since = now_ms - last_step_ms;
    if (since < TimeW'(step_interval_ms())) begin
      return;
    end
    last_step_ms = now_ms;
    for (int unsigned i = 0; i < regs.tail_length; i++) begin
      bri     = int'(FullLevel) / (int'(regs.tail_length) - i);
      w.idx   = PixIdxW'((head_pos + i) % RingPixels);
      w.red   = scale_chan(regs.base_red, bri);
      w.green = scale_chan(regs.base_green, bri);
      w.blue  = scale_chan(regs.base_blue, bri);
      w.last  = (i + 1 == regs.tail_length);
      pixel_writes_q.push_back(w);
    end
    head_pos = (head_pos + 1) % RingPixels;
  endtask

  task automatic check_pixel_write();
    pixel_wr_t             w;
    logic [OutDataW-1:0]   want;
    if (pixel_writes_q.size() == 0) begin
      report_mismatch($sformatf("pixel transfer with none pending: tdata %08h tlast %0b",
                                m_axis_tdata, m_axis_tlast));
      return;
    end
    w    = pixel_writes_q.pop_front();
    want = OutDataW'({w.blue, w.green, w.red, w.idx});
    if (m_axis_tdata !== want || m_axis_tlast !== w.last) begin
      report_mismatch($sformatf(
        "pixel transfer: expected idx %0d rgb %02h %02h %02h last %0b, got tdata %08h last %0b",
        w.idx, w.red, w.green, w.blue, w.last, m_axis_tdata, m_axis_tlast));
    end
  endtask

  task automatic check_reg_read();
    logic [ApbDataW-1:0] want;
    case (paddr[4:2])
      REG_BASE_RED:      want = ApbDataW'(regs.base_red);
      REG_BASE_GREEN:    want = ApbDataW'(regs.base_green);
      REG_BASE_BLUE:     want = ApbDataW'(regs.base_blue);
      REG_SPEED_SETTING: want = ApbDataW'(regs.speed_setting);
      REG_INTERVAL_MODE: want = ApbDataW'(regs.interval_mode);
      REG_TAIL_LENGTH:   want = ApbDataW'(regs.tail_length);
      default:           return;
    endcase
    if (prdata !== want) begin
      report_mismatch($sformatf("register %0d read: expected %08h, got %08h",
                                paddr[4:2], want, prdata));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs.base_red      = 8'd255;
      regs.base_green    = 8'd0;
      regs.base_blue     = 8'd0;
      regs.speed_setting = 8'd128;
      regs.interval_mode = 1'b0;
      regs.tail_length   = 5'd5;
      last_step_ms       = '0;
      head_pos           = 0;
      pixel_writes_q.delete();
      mismatches         = 0;
      writes_pending_o  <= 0;
      mismatches_o      <= 0;
    end else begin
      if (psel && penable && pready && pwrite) begin
        case (paddr[4:2])
          REG_BASE_RED:      regs.base_red      = pwdata[ChanW-1:0];
          REG_BASE_GREEN:    regs.base_green    = pwdata[ChanW-1:0];
          REG_BASE_BLUE:     regs.base_blue     = pwdata[ChanW-1:0];
          REG_SPEED_SETTING: regs.speed_setting = pwdata[ChanW-1:0];
          REG_INTERVAL_MODE: regs.interval_mode = pwdata[0];
          REG_TAIL_LENGTH:   regs.tail_length   = pwdata[TailW-1:0];
          default: ;
        endcase
      end
      if (psel && penable && pready && !pwrite) begin
        check_reg_read();
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_frame(s_axis_tdata);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        check_pixel_write();
      end
      writes_pending_o <= pixel_writes_q.size();
      mismatches_o     <= mismatches;
    end
  end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
module tb;
  import lcc_pkg::*;

  localparam int         RingPixels  = 16;
  localparam int         CycleLimit  = 600000;
  localparam int         DrainCycles = 16;
  localparam logic [2:0] RegSpare0   = 3'd6;
  localparam logic [2:0] RegSpare1   = 3'd7;

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [TimeW-1:0]    s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [ApbAddrW-1:0] paddr         = '0;
  logic [ApbDataW-1:0] pwdata        = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  int writes_pending;
  int mismatches;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int cycle_count   = 0;

  led_comet_chase_generator #(
    .RING_PIXELS(RingPixels)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  lcc_frame_checker #(
    .RingPixels(RingPixels)
  ) i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tlast    (m_axis_tlast),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .writes_pending_o(writes_pending),
    .mismatches_o    (mismatches)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_time(input logic [TimeW-1:0] now_ms);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= now_ms;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic apb_access(input logic wr, input logic [2:0] idx,
                            input logic [ApbDataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
  endtask

  // hold the block idle: drop tvalid and wait out every pending pixel transfer
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (writes_pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [ApbDataW-1:0] red, input logic [ApbDataW-1:0] green,
                            input logic [ApbDataW-1:0] blue, input logic [ApbDataW-1:0] speed,
                            input logic [ApbDataW-1:0] mode, input logic [ApbDataW-1:0] tail);
    apb_access(1'b1, REG_BASE_RED, red);
    apb_access(1'b1, REG_BASE_GREEN, green);
    apb_access(1'b1, REG_BASE_BLUE, blue);
    apb_access(1'b1, REG_SPEED_SETTING, speed);
    apb_access(1'b1, REG_INTERVAL_MODE, mode);
    apb_access(1'b1, REG_TAIL_LENGTH, tail);
    apb_access(1'b0, REG_BASE_RED, '0);
    apb_access(1'b0, REG_BASE_GREEN, '0);
    apb_access(1'b0, REG_BASE_BLUE, '0);
    apb_access(1'b0, REG_SPEED_SETTING, '0);
    apb_access(1'b0, REG_INTERVAL_MODE, '0);
    apb_access(1'b0, REG_TAIL_LENGTH, '0);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    logic [TimeW-1:0] stamp_ms;
    int               pick;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings, fixed interval: first step only once the interval has passed
    send_time(32'd0);
    send_time(32'd39);
    send_time(32'd40);
    send_time(32'd79);
    send_time(32'd80);
    settle();

    // full ring, shortest mapped interval
    set_config(32'd255, 32'd128, 32'd1, 32'd255, 32'd1, 32'd16);
    send_time(32'd90);
    send_time(32'd99);
    send_time(32'd100);
    settle();

    // zero tail: steps still fire and advance the head, but emit nothing
    set_config(32'd0, 32'd255, 32'd255, 32'd0, 32'd1, 32'd0);
    send_time(32'hFFFF_FFFF);
    send_time(32'd198);
    send_time(32'd199);
    settle();

    // unmapped registers are ignored; tail longer than the ring wraps
    apb_access(1'b1, RegSpare0, $urandom());
    apb_access(1'b1, RegSpare1, $urandom());
    set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FF00, 32'hFFFF_FFFF,
               32'hFFFF_FFFF);
    send_time(32'h8000_0000);
    send_time(32'h8000_00C7);
    send_time(32'hAAAA_AAAA);
    send_time(32'h5555_5555);
    settle();

    set_config(32'd17, 32'd200, 32'd93, 32'd128, 32'd0, 32'd1);
    send_time(32'h5555_557D);
    send_time(32'h5555_5580);
    stamp_ms = 32'h5555_5580;

    for (int ph = 0; ph < 4; ph++) begin
      settle();
      case (ph)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
          set_config($urandom(), $urandom(), $urandom(), $urandom(), 32'd0,
                     32'($urandom_range(1, 16)));
        end
        1: begin
          send_idle_pct = 45;
          stall_pct     = 0;
          set_config(32'd255, 32'd0, 32'd255, 32'd255, 32'd1, 32'd1);
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 45;
          set_config($urandom(), $urandom(), $urandom(), $urandom(), 32'd1,
                     32'($urandom_range(0, 31)));
        end
        default: begin
          send_idle_pct = 15;
          stall_pct     = 15;
          set_config($urandom(), $urandom(), $urandom(), 32'd0, 32'd1,
                     32'($urandom_range(2, 8)));
        end
      endcase
      repeat (40) begin
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          stamp_ms = stamp_ms + $urandom_range(0, 250);
        end else if (pick < 95) begin
          stamp_ms = $urandom();
        end
        send_time(stamp_ms);
      end
    end
    settle();

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
